>>> hw/rtl/ebtc_pkg.sv
// shared types, constants and a helper function for the ext2 block type classifier
package ebtc_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned BLK_W    = 32;
  localparam int unsigned BPG_W    = 20;
  localparam int unsigned META_W   = 16;
  localparam int unsigned GCNT_W   = 25;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned GRP_W    = 24;
  localparam int unsigned OFF_W    = 19;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  // register reset values and clamps
  localparam logic [BPG_W-1:0]   BPG_MAX    = 20'd524288;
  localparam logic [GCNT_W-1:0]  GCNT_MAX   = 25'd16777216;
  localparam logic               FDB_RST    = 1'b1;
  localparam logic [BPG_W-1:0]   BPG_RST    = 20'd8192;
  localparam logic [META_W-1:0]  BMS_RST    = 16'd3;
  localparam logic [META_W-1:0]  ITB_RST    = 16'd256;
  localparam logic [GCNT_W-1:0]  GCNT_RST   = 25'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_RST  = 5'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_GROUP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP_META_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_TABLE_BLOCKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT        = 3'd5;

  // operation codes
  localparam logic OP_BYTE_OFFSET  = 1'b0;
  localparam logic OP_BLOCK_NUMBER = 1'b1;

  // block kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_BOOT    = 3'd0,
    KIND_SUPER   = 3'd1,
    KIND_DESC    = 3'd2,
    KIND_BBITMAP = 3'd3,
    KIND_IBITMAP = 3'd4,
    KIND_ITABLE  = 3'd5,
    KIND_DATA    = 3'd6
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_CLASS,
    ST_OUT
  } state_t;

  // powers of 3, 5 and 7 below 2^24 (sparse superblock backup groups)
  localparam int unsigned POW_N = 33;
  localparam logic [GRP_W-1:0] POW_TAB [POW_N] = '{
    24'd3, 24'd9, 24'd27, 24'd81, 24'd243, 24'd729, 24'd2187, 24'd6561,
    24'd19683, 24'd59049, 24'd177147, 24'd531441, 24'd1594323, 24'd4782969,
    24'd14348907,
    24'd5, 24'd25, 24'd125, 24'd625, 24'd3125, 24'd15625, 24'd78125,
    24'd390625, 24'd1953125, 24'd9765625,
    24'd7, 24'd49, 24'd343, 24'd2401, 24'd16807, 24'd117649, 24'd823543,
    24'd5764801
  };

  // group carries a superblock backup: 0, 1 or a power of 3, 5 or 7
  function automatic logic is_sparse(input logic [GRP_W-1:0] g);
    logic hit;
    hit = (g == 24'd0) || (g == 24'd1);
    for (int i = 0; i < POW_N; i++) begin
      hit = hit | (g == POW_TAB[i]);
    end
    return hit;
  endfunction

endpackage

>>> hw/rtl/ebtc_in_if.sv
// input channel: addressing mode and disk address
interface ebtc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [ebtc_pkg::ADDR_W-1:0]     disk_address;

  modport source (output valid, output operation, output disk_address, input ready);
  modport sink   (input valid, input operation, input disk_address, output ready);
endinterface

>>> hw/rtl/ebtc_out_if.sv
// result channel: block classification
interface ebtc_out_if;
  logic                            valid;
  logic                            ready;
  logic [ebtc_pkg::KIND_W-1:0]     block_kind;
  logic                            invalid;
  logic [ebtc_pkg::BLK_W-1:0]      block_number;
  logic [ebtc_pkg::GRP_W-1:0]      group_index;
  logic [ebtc_pkg::OFF_W-1:0]      offset_in_group;
  logic                            is_backup;

  modport source (output valid, output block_kind, output invalid, output block_number,
                  output group_index, output offset_in_group, output is_backup,
                  input ready);
  modport sink   (input valid, input block_kind, input invalid, input block_number,
                  input group_index, input offset_in_group, input is_backup,
                  output ready);
endinterface

>>> hw/rtl/ebtc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module ebtc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ebtc_pkg::BLK_W-1:0]    dividend,
  input  logic [ebtc_pkg::BPG_W-1:0]    divisor,
  output logic                          done,
  output logic [ebtc_pkg::BLK_W-1:0]    quotient,
  output logic [ebtc_pkg::BPG_W-1:0]    remainder
);

  logic [ebtc_pkg::BLK_W-1:0] dvd_r, dvd_nxt;
  logic [ebtc_pkg::BPG_W-1:0] rem_r, rem_nxt;
  logic [ebtc_pkg::BPG_W-1:0] dvsr_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [ebtc_pkg::BPG_W:0]   rem_sh;
  logic [ebtc_pkg::BPG_W+1:0] diff;
  logic                       fits;

  // shared subtract and compare step
  always_comb begin
    rem_sh  = {rem_r, dvd_r[ebtc_pkg::BLK_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvsr_r};
    fits    = ~diff[ebtc_pkg::BPG_W+1];
    rem_nxt = fits ? diff[ebtc_pkg::BPG_W-1:0] : rem_sh[ebtc_pkg::BPG_W-1:0];
    dvd_nxt = {dvd_r[ebtc_pkg::BLK_W-2:0], fits};
  end

  // control: count 32 steps after start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/ext2_block_type_classifier.sv
// top level of the ext2 block type classifier
//
// in_chan carries one transaction per address: operation 0 treats disk_address
// as a byte offset and shifts it right by block_shift, operation 1 takes it as
// a block number. out_chan returns exactly one classification per input: block
// kind, invalid flag, block number, group index, offset in group and backup flag.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, which the block itself does not enforce. Writes
// to an index above 5 are ignored. One address is handled at a time: after the
// input transaction the sequencer starts the divider, the bit-serial divider
// computes group and offset, and after its completion a classify step loads
// the result into the output register. in_chan.ready is high only while idle,
// so a new transaction is taken only after the previous result has been taken.
// A stalled receiver holds the result in the output register and the block
// takes no new input until the result is taken.
// Synchronous reset loads the register defaults and returns to idle.
module ext2_block_type_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ebtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ebtc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  ebtc_in_if.sink                            in_chan,
  ebtc_out_if.source                         out_chan
);

  ebtc_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic                             fdb_r;
  logic [ebtc_pkg::BPG_W-1:0]       bpg_r;
  logic [ebtc_pkg::META_W-1:0]      bms_r;
  logic [ebtc_pkg::META_W-1:0]      itb_r;
  logic [ebtc_pkg::GCNT_W-1:0]      gcnt_r;
  logic [ebtc_pkg::SHIFT_W-1:0]     shift_r;

  // working registers
  logic [ebtc_pkg::BLK_W-1:0]       blk_r;
  logic [ebtc_pkg::KIND_W-1:0]      kind_r;
  logic                             inval_r;
  logic [ebtc_pkg::GRP_W-1:0]       grp_r;
  logic [ebtc_pkg::OFF_W-1:0]       off_r;
  logic                             backup_r;

  logic                             in_ready;
  logic                             out_valid;
  logic                             div_start;
  logic                             div_done;
  logic [ebtc_pkg::BLK_W-1:0]       div_q;
  logic [ebtc_pkg::BPG_W-1:0]       div_r;
  logic [ebtc_pkg::ADDR_W-1:0]      addr_sh;
  logic [ebtc_pkg::BLK_W-1:0]       blk_in;
  logic [ebtc_pkg::BLK_W-1:0]       rel;
  logic [ebtc_pkg::BPG_W-1:0]       bpg_eff;
  logic [ebtc_pkg::GCNT_W-1:0]      gcnt_eff;
  logic                             in_acc;
  logic                             out_acc;

  // classification results
  logic [ebtc_pkg::KIND_W-1:0]      kind_c;
  logic                             inval_c;
  logic [ebtc_pkg::GRP_W-1:0]       grp_c;
  logic [ebtc_pkg::OFF_W-1:0]       off_c;
  logic                             backup_c;

  assign in_acc  = in_chan.valid && in_ready;
  assign out_acc = out_valid && out_chan.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fdb_r   <= ebtc_pkg::FDB_RST;
      bpg_r   <= ebtc_pkg::BPG_RST;
      bms_r   <= ebtc_pkg::BMS_RST;
      itb_r   <= ebtc_pkg::ITB_RST;
      gcnt_r  <= ebtc_pkg::GCNT_RST;
      shift_r <= ebtc_pkg::SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ebtc_pkg::REG_FIRST_DATA_BLOCK:   fdb_r   <= cfg_wdata[0];
        ebtc_pkg::REG_BLOCKS_PER_GROUP:   bpg_r   <= cfg_wdata[ebtc_pkg::BPG_W-1:0];
        ebtc_pkg::REG_BACKUP_META_START:  bms_r   <= cfg_wdata[ebtc_pkg::META_W-1:0];
        ebtc_pkg::REG_INODE_TABLE_BLOCKS: itb_r   <= cfg_wdata[ebtc_pkg::META_W-1:0];
        ebtc_pkg::REG_GROUP_COUNT:        gcnt_r  <= cfg_wdata[ebtc_pkg::GCNT_W-1:0];
        ebtc_pkg::REG_BLOCK_SHIFT:        shift_r <= cfg_wdata[ebtc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped group size and group count
  always_comb begin
    if (bpg_r == '0) begin
      bpg_eff = ebtc_pkg::BPG_W'(1);
    end else if (bpg_r > ebtc_pkg::BPG_MAX) begin
      bpg_eff = ebtc_pkg::BPG_MAX;
    end else begin
      bpg_eff = bpg_r;
    end
    gcnt_eff = (gcnt_r > ebtc_pkg::GCNT_MAX) ? ebtc_pkg::GCNT_MAX : gcnt_r;
  end

  // byte offset to block number
  always_comb begin
    addr_sh = in_chan.disk_address >> shift_r;
    if (in_chan.operation == ebtc_pkg::OP_BLOCK_NUMBER) begin
      blk_in = in_chan.disk_address[ebtc_pkg::BLK_W-1:0];
    end else begin
      blk_in = addr_sh[ebtc_pkg::BLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r <= blk_in;
    end
  end

  // block number relative to group zero
  assign rel = blk_r - {{(ebtc_pkg::BLK_W-1){1'b0}}, fdb_r};

  ebtc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rel),
    .divisor   (bpg_eff),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // classify the offset against the group layout
  always_comb begin
    logic                           is_boot;
    logic                           in_range;
    logic                           sparse;
    logic [ebtc_pkg::OFF_W-1:0]     off;
    logic [ebtc_pkg::OFF_W-1:0]     rem;
    logic [ebtc_pkg::OFF_W-1:0]     itb_lim;
    is_boot  = fdb_r && (blk_r == '0);
    in_range = div_q < {{(ebtc_pkg::BLK_W-ebtc_pkg::GCNT_W){1'b0}}, gcnt_eff};
    sparse   = ebtc_pkg::is_sparse(div_q[ebtc_pkg::GRP_W-1:0]);
    off      = div_r[ebtc_pkg::OFF_W-1:0];
    itb_lim  = {3'b000, itb_r} + ebtc_pkg::OFF_W'(2);
    rem      = off;
    kind_c   = ebtc_pkg::KIND_BOOT;
    inval_c  = 1'b0;
    backup_c = 1'b0;
    grp_c    = div_q[ebtc_pkg::GRP_W-1:0];
    off_c    = off;
    if (is_boot) begin
      grp_c = '0;
      off_c = '0;
    end else if (!in_range) begin
      inval_c = 1'b1;
      if (div_q[ebtc_pkg::BLK_W-1:ebtc_pkg::GRP_W] != '0) begin
        grp_c = '1;
      end
    end else begin
      backup_c = sparse;
      if (sparse && (off == '0)) begin
        kind_c = ebtc_pkg::KIND_SUPER;
      end else if (sparse && (off < {3'b000, bms_r})) begin
        kind_c = ebtc_pkg::KIND_DESC;
      end else begin
        if (sparse) begin
          rem = off - {3'b000, bms_r};
        end
        if (rem == '0) begin
          kind_c = ebtc_pkg::KIND_BBITMAP;
        end else if (rem == ebtc_pkg::OFF_W'(1)) begin
          kind_c = ebtc_pkg::KIND_IBITMAP;
        end else if (rem < itb_lim) begin
          kind_c = ebtc_pkg::KIND_ITABLE;
        end else if ({1'b0, rem} < bpg_eff) begin
          kind_c = ebtc_pkg::KIND_DATA;
        end else begin
          inval_c = 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == ebtc_pkg::ST_CLASS) begin
      kind_r   <= kind_c;
      inval_r  <= inval_c;
      grp_r    <= grp_c;
      off_r    <= off_c;
      backup_r <= backup_c;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ebtc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ebtc_pkg::ST_IDLE:  if (in_acc) state_nxt = ebtc_pkg::ST_START;
      ebtc_pkg::ST_START: state_nxt = ebtc_pkg::ST_DIV;
      ebtc_pkg::ST_DIV:   if (div_done) state_nxt = ebtc_pkg::ST_CLASS;
      ebtc_pkg::ST_CLASS: state_nxt = ebtc_pkg::ST_OUT;
      ebtc_pkg::ST_OUT:   if (out_acc) state_nxt = ebtc_pkg::ST_IDLE;
      default:            state_nxt = ebtc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ebtc_pkg::ST_IDLE:  in_ready  = 1'b1;
      ebtc_pkg::ST_START: div_start = 1'b1;
      ebtc_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign in_chan.ready            = in_ready;
  assign out_chan.valid           = out_valid;
  assign out_chan.block_kind      = kind_r;
  assign out_chan.invalid         = inval_r;
  assign out_chan.block_number    = blk_r;
  assign out_chan.group_index     = grp_r;
  assign out_chan.offset_in_group = off_r;
  assign out_chan.is_backup       = backup_r;

endmodule
